// File: hw/rtl/aoss_pkg.sv
// Package for the AV1 OBU stream scanner: scan state, result types and byte masks.
// No dependencies; used by the channel interfaces, aoss_step and the top level.
`default_nettype none

package aoss_pkg;

   // Width of the OBU payload length counter; a size that does not fit is an error.
   localparam int LENGTH_BITS   = 24;
   localparam int COUNT_BITS    = 24;
   localparam int TEMPORAL_BITS = 3;
   localparam int SPATIAL_BITS  = 2;

   // LEB128 size field: at most eight bytes of seven bits each.
   localparam int LEB_BYTES     = 8;
   localparam int LEB_DIGIT     = 7;
   localparam int LEB_IDX_BITS  = $clog2(LEB_BYTES);
   localparam int LEB_PART_BITS = LEB_BYTES * LEB_DIGIT;
   localparam int LEB_SHIFT_BITS = $clog2(LEB_PART_BITS);

   localparam logic [LEB_IDX_BITS-1:0]   LEB_IDX_LAST  = LEB_IDX_BITS'(LEB_BYTES - 1);
   localparam logic [LEB_SHIFT_BITS-1:0] LEB_DIGIT_W   = LEB_SHIFT_BITS'(LEB_DIGIT);
   localparam logic [COUNT_BITS-1:0]     COUNT_MAX     = '1;

   // Header and extension byte masks.
   localparam logic [7:0] HDR_ILLEGAL_MASK = 8'h81;  // forbidden bit and reserved bit
   localparam logic [7:0] HDR_EXT_FLAG     = 8'h04;
   localparam logic [7:0] HDR_SIZE_FLAG    = 8'h02;
   localparam logic [7:0] EXT_RSVD_MASK    = 8'h07;
   localparam logic [7:0] LEB_VALUE_MASK   = 8'h7f;
   localparam logic [7:0] LEB_MORE_FLAG    = 8'h80;

   localparam logic [3:0] OBU_TYPE_NONE    = 4'd0;
   localparam logic [3:0] OBU_TYPE_SEQ_HDR = 4'd1;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_EXT,
      PH_SIZE,
      PH_PAYLOAD,
      PH_REST
   } phase_type;

   typedef struct packed {
      phase_type                phase;
      logic                     size_flag;
      logic [LENGTH_BITS-1:0]   size_accum;
      logic [LEB_IDX_BITS-1:0]  size_idx;
      logic [LENGTH_BITS-1:0]   payload_left;
      logic                     error_seen;
      logic [COUNT_BITS-1:0]    count;
      logic [TEMPORAL_BITS-1:0] temporal_max;
      logic [SPATIAL_BITS-1:0]  spatial_max;
      logic                     seq_seen;
   } scan_state_type;

   typedef struct packed {
      logic                     scan_ok;
      logic [COUNT_BITS-1:0]    obu_total;
      logic [TEMPORAL_BITS-1:0] temporal_id_max;
      logic [SPATIAL_BITS-1:0]  spatial_id_max;
      logic                     saw_sequence_header;
   } scan_result_type;

   localparam scan_state_type SCAN_IDLE = '{
      phase:        PH_HEADER,
      size_flag:    1'b0,
      size_accum:   '0,
      size_idx:     '0,
      payload_left: '0,
      error_seen:   1'b0,
      count:        '0,
      temporal_max: '0,
      spatial_max:  '0,
      seq_seen:     1'b0
   };

endpackage

`default_nettype wire

// File: hw/rtl/aoss_ifs.sv
// Valid/ready channel interfaces for the OBU stream scanner: byte requests and scan results.
// Depends on aoss_pkg for field widths.
`default_nettype none

interface aoss_req_if
   import aoss_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aoss_rsp_if
   import aoss_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     scan_ok;
   logic [COUNT_BITS-1:0]    obu_total;
   logic [TEMPORAL_BITS-1:0] temporal_id_max;
   logic [SPATIAL_BITS-1:0]  spatial_id_max;
   logic                     saw_sequence_header;

   modport source (output valid, output scan_ok, output obu_total, output temporal_id_max,
                   output spatial_id_max, output saw_sequence_header, input ready);
   modport sink   (input valid, input scan_ok, input obu_total, input temporal_id_max,
                   input spatial_id_max, input saw_sequence_header, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/av1_obu_stream_scanner.sv
// AV1 OBU stream scanner top level: input register, scan state, result register.
// Depends on aoss_pkg, aoss_ifs (channel interfaces) and aoss_step.
`default_nettype none

// Scans an AV1 buffer one byte per item, one item per cycle sustained. Each byte is
// captured in an input register, run through one pass of the header/extension/LEB128/
// payload walker and folded into the scan state in the same cycle, so the byte rate is
// set by that single state update. The byte flagged last_byte, when it leaves the input
// register, puts one registered result item on rsp_if; any malformed or truncated
// buffer gives an all-zero result. Non-final bytes keep flowing while a result waits on
// rsp_if; only a final byte holds in the input register until the result register is free.
// The scan state returns to idle after every final byte, ready for the next buffer.
module av1_obu_stream_scanner
   import aoss_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   aoss_req_if.sink   req_if,
   aoss_rsp_if.source rsp_if
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   scan_state_type  st_ff, st_in;
   scan_state_type  st_next;
   scan_result_type res_next;
   scan_result_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic advance;
   logic byte_fire;
   logic req_take;

   // a final byte may only move on when the result register can take its result
   assign advance   = !(in_last_ff && rsp_valid_ff && !rsp_if.ready);
   assign byte_fire = in_valid_ff && advance;
   assign req_take  = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;

   aoss_step u_step (
      .cur       (st_ff),
      .data_byte (in_byte_ff),
      .nxt       (st_next),
      .res       (res_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.data_byte;
         in_last_in  = req_if.last_byte;
      end else if (byte_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      st_in = st_ff;
      if (byte_fire) begin
         st_in = in_last_ff ? SCAN_IDLE : st_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (byte_fire && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_next;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_ff        <= SCAN_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.scan_ok             = rsp_ff.scan_ok;
   assign rsp_if.obu_total           = rsp_ff.obu_total;
   assign rsp_if.temporal_id_max     = rsp_ff.temporal_id_max;
   assign rsp_if.spatial_id_max      = rsp_ff.spatial_id_max;
   assign rsp_if.saw_sequence_header = rsp_ff.saw_sequence_header;

`ifndef SYNTHESIS
   // a new result only ever follows a final byte leaving the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(in_valid_ff && in_last_ff))
      else $error("result without a final byte");

   // a failed scan reports nothing else
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.scan_ok) |-> (rsp_ff.obu_total == '0 &&
      rsp_ff.temporal_id_max == '0 && rsp_ff.spatial_id_max == '0 &&
      !rsp_ff.saw_sequence_header))
      else $error("nonzero fields on failed scan");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.scan_ok) |-> (rsp_ff.obu_total != '0))
      else $error("clean scan with no OBU");

   // payload phase is never entered with nothing to skip
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == PH_PAYLOAD && !st_ff.error_seen) |-> (st_ff.payload_left != '0))
      else $error("payload phase with zero length");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/aoss_step.sv
// Per-byte next-state logic of the OBU walker and the end-of-buffer result.
// Depends on aoss_pkg.
`default_nettype none

module aoss_step
   import aoss_pkg::*;
(
   input  scan_state_type  cur,
   input  logic [7:0]      data_byte,
   output scan_state_type  nxt,
   output scan_result_type res
);

   logic [3:0]                obu_type;
   logic [LEB_PART_BITS-1:0]  leb_part;
   logic [LENGTH_BITS-1:0]    leb_accum;
   logic [LENGTH_BITS-1:0]    left_dec;
   logic [TEMPORAL_BITS-1:0]  ext_tid;
   logic [SPATIAL_BITS-1:0]   ext_sid;

   assign obu_type = data_byte[6:3];
   assign ext_tid  = data_byte[7:5];
   assign ext_sid  = data_byte[4:3];
   assign leb_part = LEB_PART_BITS'(data_byte & LEB_VALUE_MASK)
                     << ({{(LEB_SHIFT_BITS-LEB_IDX_BITS){1'b0}}, cur.size_idx} * LEB_DIGIT_W);
   assign leb_accum = cur.size_accum | leb_part[LENGTH_BITS-1:0];
   assign left_dec  = cur.payload_left - LENGTH_BITS'(1);

   // next state
   always_comb begin
      nxt = cur;
      if (!cur.error_seen) begin
         case (cur.phase)
            PH_HEADER: begin
               if ((data_byte & HDR_ILLEGAL_MASK) != 8'h00 || obu_type == OBU_TYPE_NONE) begin
                  nxt.error_seen = 1'b1;
               end else begin
                  if (cur.count != COUNT_MAX) begin
                     nxt.count = cur.count + COUNT_BITS'(1);
                  end
                  if (obu_type == OBU_TYPE_SEQ_HDR) begin
                     nxt.seq_seen = 1'b1;
                  end
                  nxt.size_flag  = (data_byte & HDR_SIZE_FLAG) != 8'h00;
                  nxt.size_accum = '0;
                  nxt.size_idx   = '0;
                  if ((data_byte & HDR_EXT_FLAG) != 8'h00) begin
                     nxt.phase = PH_EXT;
                  end else if ((data_byte & HDR_SIZE_FLAG) != 8'h00) begin
                     nxt.phase = PH_SIZE;
                  end else begin
                     nxt.phase = PH_REST;
                  end
               end
            end
            PH_EXT: begin
               if ((data_byte & EXT_RSVD_MASK) != 8'h00) begin
                  nxt.error_seen = 1'b1;
               end else begin
                  if (ext_tid > cur.temporal_max) begin
                     nxt.temporal_max = ext_tid;
                  end
                  if (ext_sid > cur.spatial_max) begin
                     nxt.spatial_max = ext_sid;
                  end
                  nxt.phase = cur.size_flag ? PH_SIZE : PH_REST;
               end
            end
            PH_SIZE: begin
               if ((leb_part >> LENGTH_BITS) != '0) begin
                  nxt.error_seen = 1'b1;
               end else begin
                  nxt.size_accum = leb_accum;
                  if ((data_byte & LEB_MORE_FLAG) != 8'h00) begin
                     if (cur.size_idx == LEB_IDX_LAST) begin
                        nxt.error_seen = 1'b1;
                     end else begin
                        nxt.size_idx = cur.size_idx + LEB_IDX_BITS'(1);
                     end
                  end else begin
                     nxt.payload_left = leb_accum;
                     nxt.phase        = (leb_accum != '0) ? PH_PAYLOAD : PH_HEADER;
                  end
               end
            end
            PH_PAYLOAD: begin
               nxt.payload_left = left_dec;
               if (left_dec == '0) begin
                  nxt.phase = PH_HEADER;
               end
            end
            default: begin
               // unsized OBU: rest of the buffer is its payload
            end
         endcase
      end
   end

   // result seen after the current byte, used when it is the last one
   always_comb begin
      res = '0;
      if (!nxt.error_seen && (nxt.phase inside {PH_HEADER, PH_REST}) && nxt.count != '0) begin
         res.scan_ok             = 1'b1;
         res.obu_total           = nxt.count;
         res.temporal_id_max     = nxt.temporal_max;
         res.spatial_id_max      = nxt.spatial_max;
         res.saw_sequence_header = nxt.seq_seen;
      end
   end

endmodule

`default_nettype wire
